@@ src/dstw_pkg.sv @@
// ----------------------------------------------------------------------------
// dstw_pkg
// Shared types and constants of the source-chain tag walker: tag id codes,
// kind and fault codes, and the word that travels from decode to execute.
// ----------------------------------------------------------------------------
package dstw_pkg;

    localparam int STACK_DEPTH_DEF = 2;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [31:0] QW_BYTES = 32'd16;

    // low seven bits of the id byte
    localparam logic [6:0] ID_REFE = 7'h00;
    localparam logic [6:0] ID_CNT  = 7'h10;
    localparam logic [6:0] ID_NEXT = 7'h20;
    localparam logic [6:0] ID_REF  = 7'h30;
    localparam logic [6:0] ID_REFS = 7'h40;
    localparam logic [6:0] ID_CALL = 7'h50;
    localparam logic [6:0] ID_RET  = 7'h60;
    localparam logic [6:0] ID_END  = 7'h70;

    typedef enum logic [3:0] {
        KIND_REFE    = 4'd0,
        KIND_CNT     = 4'd1,
        KIND_NEXT    = 4'd2,
        KIND_REF     = 4'd3,
        KIND_REFS    = 4'd4,
        KIND_CALL    = 4'd5,
        KIND_RET     = 4'd6,
        KIND_END     = 4'd7,
        KIND_UNKNOWN = 4'd8
    } kind_t;

    typedef enum logic [1:0] {
        FAULT_NONE      = 2'd0,
        FAULT_OVERFLOW  = 2'd1,
        FAULT_UNDERFLOW = 2'd2
    } fault_t;

    // decoded tag, from decode to execute
    typedef struct packed {
        logic        first_tag;
        kind_t       kind;
        logic        irq_flag;
        logic [31:0] data_addr;
        logic [15:0] data_qwc;
        logic [31:0] next_addr;
        logic [31:0] ret_addr;
    } entry_t;

    typedef struct packed {
        kind_t       kind;
        logic        irq_flag;
        logic [31:0] data_addr;
        logic [15:0] data_qwc;
        logic        has_next;
        logic [31:0] next_tag_addr;
        fault_t      fault;
        logic        stack_left;
    } result_t;

endpackage

@@ src/dstw_tag_if.sv @@
// ----------------------------------------------------------------------------
// dstw_tag_if
// Input channel: one source-chain tag per word.
// ----------------------------------------------------------------------------
interface dstw_tag_if;
    logic        valid;
    logic        ready;
    logic        first_tag;
    logic [31:0] tag_addr;
    logic [7:0]  tag_id;
    logic [15:0] tag_qwc;
    logic [31:0] tag_target;

    modport source (
        output valid, first_tag, tag_addr, tag_id, tag_qwc, tag_target,
        input  ready
    );
    modport sink (
        input  valid, first_tag, tag_addr, tag_id, tag_qwc, tag_target,
        output ready
    );
endinterface

@@ src/dstw_res_if.sv @@
// ----------------------------------------------------------------------------
// dstw_res_if
// Output channel: one decoded tag result per word.
// ----------------------------------------------------------------------------
interface dstw_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic        irq_flag;
    logic [31:0] data_addr;
    logic [15:0] data_qwc;
    logic        has_next;
    logic [31:0] next_tag_addr;
    logic [1:0]  fault;
    logic        stack_left;

    modport source (
        output valid, kind, irq_flag, data_addr, data_qwc, has_next,
               next_tag_addr, fault, stack_left,
        input  ready
    );
    modport sink (
        input  valid, kind, irq_flag, data_addr, data_qwc, has_next,
               next_tag_addr, fault, stack_left,
        output ready
    );
endinterface

@@ src/dstw_front.sv @@
// ----------------------------------------------------------------------------
// dstw_front
// Tag decode: classifies the id byte and forms the candidate addresses
// (data, next tag, return) so the execute side only touches the stack.
// ----------------------------------------------------------------------------
module dstw_front (
    dstw_tag_if.sink         tag,
    input  logic             q_ready,
    output logic             push,
    output dstw_pkg::entry_t push_item
);
    import dstw_pkg::*;

    logic [31:0] after;
    logic [31:0] skip;
    logic [16:0] qwc_plus;

    assign tag.ready = q_ready;
    assign push      = tag.valid && q_ready;

    always_comb
    begin
        after    = tag.tag_addr + QW_BYTES;
        // tag itself plus its payload, in quadwords
        qwc_plus = {1'b0, tag.tag_qwc} + 17'd1;
        skip     = tag.tag_addr + {11'd0, qwc_plus, 4'd0};

        push_item.first_tag = tag.first_tag;
        push_item.irq_flag  = tag.tag_id[7];
        push_item.data_qwc  = tag.tag_qwc;
        push_item.ret_addr  = skip;
        push_item.kind      = KIND_UNKNOWN;
        push_item.data_addr = '0;
        push_item.next_addr = '0;

        case (tag.tag_id[6:0])
            ID_REFE:
            begin
                push_item.kind      = KIND_REFE;
                push_item.data_addr = tag.tag_target;
            end
            ID_CNT:
            begin
                push_item.kind      = KIND_CNT;
                push_item.data_addr = after;
                push_item.next_addr = skip;
            end
            ID_NEXT:
            begin
                push_item.kind      = KIND_NEXT;
                push_item.data_addr = after;
                push_item.next_addr = tag.tag_target;
            end
            ID_REF:
            begin
                push_item.kind      = KIND_REF;
                push_item.data_addr = tag.tag_target;
                push_item.next_addr = after;
            end
            ID_REFS:
            begin
                push_item.kind      = KIND_REFS;
                push_item.data_addr = tag.tag_target;
                push_item.next_addr = after;
            end
            ID_CALL:
            begin
                push_item.kind      = KIND_CALL;
                push_item.data_addr = after;
                push_item.next_addr = tag.tag_target;
            end
            ID_RET:
            begin
                push_item.kind      = KIND_RET;
                push_item.data_addr = after;
            end
            ID_END:
            begin
                push_item.kind      = KIND_END;
                push_item.data_addr = after;
            end
            default:
            begin
                push_item.kind = KIND_UNKNOWN;
            end
        endcase
    end

endmodule

@@ src/dstw_queue.sv @@
// ----------------------------------------------------------------------------
// dstw_queue
// Short FIFO of decoded tags between decode and execute.
// ----------------------------------------------------------------------------
module dstw_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dstw_pkg::entry_t push_item,
    output logic             not_full,
    output logic             q_valid,
    output dstw_pkg::entry_t q_item,
    input  logic             pop
);
    import dstw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign not_full = count_reg != CNT_W'(QUEUE_DEPTH);
    assign q_valid  = count_reg != '0;
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !not_full |-> !push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid |-> !pop)
        else $error("pop from empty queue");

endmodule

@@ src/dstw_back.sv @@
// ----------------------------------------------------------------------------
// dstw_back
// Tag execute: return stack push and pop, fault detection and the
// registered result word.
// ----------------------------------------------------------------------------
module dstw_back #(
    parameter int STACK_DEPTH = dstw_pkg::STACK_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  dstw_pkg::entry_t q_item,
    output logic             pop,
    dstw_res_if.source       res
);
    import dstw_pkg::*;

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [31:0]        stack_reg [STACK_DEPTH];
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [DEPTH_W-1:0] depth_eff;
    logic               res_valid_reg, res_valid_next;
    result_t            res_reg, res_next;
    logic               do_push;
    logic [IDX_W-1:0]   wr_idx;
    logic [IDX_W-1:0]   rd_idx;

    assign pop = q_valid && (!res_valid_reg || res.ready);

    always_comb
    begin
        // a first tag sees an empty stack
        depth_eff  = q_item.first_tag ? '0 : depth_reg;
        depth_next = depth_eff;
        do_push    = 1'b0;
        wr_idx     = depth_eff[IDX_W-1:0];
        rd_idx     = depth_next[IDX_W-1:0];

        res_next.kind          = q_item.kind;
        res_next.irq_flag      = q_item.irq_flag;
        res_next.data_addr     = q_item.data_addr;
        res_next.data_qwc      = q_item.data_qwc;
        res_next.has_next      = 1'b0;
        res_next.next_tag_addr = '0;
        res_next.fault         = FAULT_NONE;

        case (q_item.kind)
            KIND_CNT, KIND_NEXT, KIND_REF, KIND_REFS:
            begin
                res_next.has_next      = 1'b1;
                res_next.next_tag_addr = q_item.next_addr;
            end
            KIND_CALL:
            begin
                if (depth_eff >= DEPTH_W'(STACK_DEPTH))
                begin
                    res_next.fault = FAULT_OVERFLOW;
                end
                else
                begin
                    do_push                = 1'b1;
                    depth_next             = depth_eff + 1'b1;
                    res_next.has_next      = 1'b1;
                    res_next.next_tag_addr = q_item.next_addr;
                end
            end
            KIND_RET:
            begin
                if (depth_eff == '0)
                begin
                    res_next.fault = FAULT_UNDERFLOW;
                end
                else
                begin
                    depth_next             = depth_eff - 1'b1;
                    rd_idx                 = depth_next[IDX_W-1:0];
                    res_next.has_next      = 1'b1;
                    res_next.next_tag_addr = stack_reg[rd_idx];
                end
            end
            default:
            begin
                res_next.has_next = 1'b0;
            end
        endcase

        res_next.stack_left = !res_next.has_next && (depth_next != '0);

        if (pop)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (pop)
            begin
                depth_reg <= depth_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
        if (pop && do_push)
        begin
            stack_reg[wr_idx] <= q_item.ret_addr;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.kind          = res_reg.kind;
    assign res.irq_flag      = res_reg.irq_flag;
    assign res.data_addr     = res_reg.data_addr;
    assign res.data_qwc      = res_reg.data_qwc;
    assign res.has_next      = res_reg.has_next;
    assign res.next_tag_addr = res_reg.next_tag_addr;
    assign res.fault         = res_reg.fault;
    assign res.stack_left    = res_reg.stack_left;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("return stack depth beyond capacity");

    a_fault_ends: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (res_reg.fault != FAULT_NONE) |-> !res_reg.has_next)
        else $error("faulted tag continues the chain");

    a_call_push: assert property (@(posedge clk) disable iff (!rst_n)
        pop && (q_item.kind == KIND_CALL) && (res_next.fault == FAULT_NONE)
        |=> depth_reg == $past(depth_eff) + 1'b1)
        else $error("call did not grow the stack");

    a_left_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.stack_left |-> !res_reg.has_next)
        else $error("stack_left on a continuing chain");

endmodule

@@ src/dma_source_chain_tag_walker.sv @@
// One source-chain tag is accepted per cycle while the queue has room and
// gives one result word. A tag enters a decode stage that classifies the id
// and forms the data, next and return addresses, waits in a two-word queue,
// and is then executed against the return stack; the result word is loaded
// into an output register when the tag leaves the queue, which happens only
// while that register is empty or being taken. Back to back tags run at one
// per cycle for as long as the result side keeps taking words; a stalled
// result side fills the queue and then holds off new tags.
// ----------------------------------------------------------------------------
// dma_source_chain_tag_walker
// Decodes source-chain DMA tags and tracks the call/ret return stack.
// ----------------------------------------------------------------------------
module dma_source_chain_tag_walker #(
    parameter int STACK_DEPTH = dstw_pkg::STACK_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dstw_tag_if.sink   tag,
    dstw_res_if.source res
);
    import dstw_pkg::*;

    logic   push;
    entry_t push_item;
    logic   not_full;
    logic   q_valid;
    entry_t q_item;
    logic   pop;

    dstw_front u_front (
        .tag       (tag),
        .q_ready   (not_full),
        .push      (push),
        .push_item (push_item)
    );

    dstw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .not_full  (not_full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop)
    );

    dstw_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (pop),
        .res     (res)
    );

endmodule

@@ tb/tag_walk_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tag_walk_checker
// Watches the tag and result channels of the source-chain tag walker. Every
// accepted tag is decoded by a local copy of the walker, return stack
// included, and every accepted result word is compared field by field with
// the oldest decoded tag still waiting.
// ----------------------------------------------------------------------------
module tag_walk_checker
    import dstw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    dstw_tag_if   tag,
    dstw_res_if   res,
    output int    fails,
    output int    pending
);

    localparam int RET_DEPTH = STACK_DEPTH_DEF;

    logic [31:0] ret_stack [RET_DEPTH];
    int          ret_depth;
    result_t     walk_results_due [$];

    initial
    begin
        fails   = 0;
        pending = 0;
    end

    task automatic report(input string msg);
        if (fails < 100)
        begin
            $display("%0t ns: %s", $time, msg);
        end
        fails++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            report($sformatf("result %s: got %h, want %h", name, got, want));
        end
    endtask

    // decode one tag against the local return stack
    function automatic result_t walk_tag(input logic first, input logic [31:0] addr,
                                         input logic [7:0] id, input logic [15:0] qwc,
                                         input logic [31:0] target);
        result_t     r;
        logic [31:0] after;
        logic [31:0] skip;
        after = addr + QW_BYTES;
        skip  = after + {12'd0, qwc, 4'd0};
        if (first)
        begin
            ret_depth = 0;
        end
        case (id[6:0])
            ID_REFE: r.kind = KIND_REFE;
            ID_CNT:  r.kind = KIND_CNT;
            ID_NEXT: r.kind = KIND_NEXT;
            ID_REF:  r.kind = KIND_REF;
            ID_REFS: r.kind = KIND_REFS;
            ID_CALL: r.kind = KIND_CALL;
            ID_RET:  r.kind = KIND_RET;
            ID_END:  r.kind = KIND_END;
            default: r.kind = KIND_UNKNOWN;
        endcase
        r.irq_flag      = id[7];
        r.data_qwc      = qwc;
        r.data_addr     = after;
        r.has_next      = 1'b0;
        r.next_tag_addr = 32'd0;
        r.fault         = FAULT_NONE;
        case (r.kind)
            KIND_REFE:
            begin
                r.data_addr = target;
            end
            KIND_CNT:
            begin
                r.has_next      = 1'b1;
                r.next_tag_addr = skip;
            end
            KIND_NEXT:
            begin
                r.has_next      = 1'b1;
                r.next_tag_addr = target;
            end
            KIND_REF, KIND_REFS:
            begin
                r.data_addr     = target;
                r.has_next      = 1'b1;
                r.next_tag_addr = after;
            end
            KIND_CALL:
            begin
                if (ret_depth >= RET_DEPTH)
                begin
                    r.fault = FAULT_OVERFLOW;
                end
                else
                begin
                    ret_stack[ret_depth] = skip;
                    ret_depth++;
                    r.has_next      = 1'b1;
                    r.next_tag_addr = target;
                end
            end
            KIND_RET:
            begin
                if (ret_depth == 0)
                begin
                    r.fault = FAULT_UNDERFLOW;
                end
                else
                begin
                    ret_depth--;
                    r.has_next      = 1'b1;
                    r.next_tag_addr = ret_stack[ret_depth];
                end
            end
            KIND_END:
            begin
                r.data_addr = after;
            end
            default:
            begin
                r.data_addr = 32'd0;
            end
        endcase
        r.stack_left = !r.has_next && (ret_depth != 0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            ret_depth = 0;
            walk_results_due.delete();
        end
        else
        begin
            if (tag.valid && tag.ready)
            begin
                walk_results_due.push_back(walk_tag(tag.first_tag, tag.tag_addr,
                                                    tag.tag_id, tag.tag_qwc,
                                                    tag.tag_target));
            end
            if (res.valid && res.ready)
            begin
                if (walk_results_due.size() == 0)
                begin
                    report($sformatf("result word with no tag waiting, kind %h", res.kind));
                end
                else
                begin
                    want = walk_results_due.pop_front();
                    check_field("kind", res.kind, want.kind);
                    check_field("irq_flag", res.irq_flag, want.irq_flag);
                    check_field("data_addr", res.data_addr, want.data_addr);
                    check_field("data_qwc", res.data_qwc, want.data_qwc);
                    check_field("has_next", res.has_next, want.has_next);
                    check_field("next_tag_addr", res.next_tag_addr, want.next_tag_addr);
                    check_field("fault", res.fault, want.fault);
                    check_field("stack_left", res.stack_left, want.stack_left);
                end
            end
        end
        pending = walk_results_due.size();
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives source-chain tags into the tag walker: a directed run over every tag
// kind, stack overflow and underflow, address wrap and chain restarts, then
// random chains with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module testbench;
    import dstw_pkg::*;

    localparam int NUM_TAGS    = 1400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;

    logic clk;
    logic rst_n;
    int   fails;
    int   pending;
    int   tags_sent;
    int   burst_left;
    int   cycle_count = 0;
    logic hold_done   = 1'b0;

    dstw_tag_if tag_ch ();
    dstw_res_if res_ch ();

    dma_source_chain_tag_walker uut (
        .clk   (clk),
        .rst_n (rst_n),
        .tag   (tag_ch),
        .res   (res_ch)
    );

    tag_walk_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag     (tag_ch),
        .res     (res_ch),
        .fails   (fails),
        .pending (pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: stall pattern changes now and then, plus one long hold-off
    int rx_mode   = 0;
    int mode_left = 0;
    int hold_left = 0;
    int rx_tick   = 0;

    always @(negedge clk)
    begin
        if (!hold_done && tags_sent >= 400)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (mode_left == 0)
        begin
            rx_mode   = $urandom_range(0, 3);
            mode_left = $urandom_range(40, 300);
        end
        mode_left--;
        rx_tick++;
        if (hold_left != 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0:       res_ch.ready <= 1'b1;
                1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       res_ch.ready <= ((rx_tick % 7) >= 3);
                default: res_ch.ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    task automatic send_tag(input logic first, input logic [31:0] addr,
                            input logic [7:0] id, input logic [15:0] qwc,
                            input logic [31:0] target);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                tag_ch.valid <= 1'b0;
                @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
        end
        burst_left--;
        tag_ch.valid      <= 1'b1;
        tag_ch.first_tag  <= first;
        tag_ch.tag_addr   <= addr;
        tag_ch.tag_id     <= id;
        tag_ch.tag_qwc    <= qwc;
        tag_ch.tag_target <= target;
        do
            @(posedge clk);
        while (!tag_ch.ready);
        tags_sent++;
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_addr();
        logic [31:0] a;
        a = $urandom();
        if ($urandom_range(0, 3) != 0)
        begin
            a[3:0] = 4'd0;
        end
        return a;
    endfunction

    function automatic logic [15:0] rand_qwc();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hffff;
            2, 3, 4: return 16'($urandom_range(0, 64));
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [7:0] rand_id();
        int   pick;
        logic irq;
        irq  = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 10) return {irq, ID_CNT};
        if (pick < 20) return {irq, ID_NEXT};
        if (pick < 30) return {irq, ID_REF};
        if (pick < 40) return {irq, ID_REFS};
        if (pick < 62) return {irq, ID_CALL};
        if (pick < 84) return {irq, ID_RET};
        if (pick < 88) return {irq, ID_END};
        if (pick < 92) return {irq, ID_REFE};
        // unknown: any id whose low nibble is not zero
        return {irq, 3'($urandom_range(0, 7)), 4'($urandom_range(1, 15))};
    endfunction

    // one chain: a head tag that restarts the stack in most chains, then random tags
    task automatic random_chain();
        int          len;
        logic        first;
        logic [31:0] addr;
        len  = $urandom_range(1, 12);
        addr = rand_addr();
        for (int i = 0; i < len; i++)
        begin
            if (i == 0)
            begin
                first = ($urandom_range(0, 7) != 0);
            end
            else
            begin
                first = ($urandom_range(0, 15) == 0);
            end
            if ($urandom_range(0, 4) == 0)
            begin
                addr = rand_addr();
            end
            send_tag(first, addr, rand_id(), rand_qwc(), rand_addr());
            addr = addr + 32'd16 * $urandom_range(1, 8);
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        tags_sent         = 0;
        burst_left        = 0;
        tag_ch.valid      = 1'b0;
        tag_ch.first_tag  = 1'b0;
        tag_ch.tag_addr   = 32'd0;
        tag_ch.tag_id     = 8'd0;
        tag_ch.tag_qwc    = 16'd0;
        tag_ch.tag_target = 32'd0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // refe, cnt, next, ref and refs, wrap-around, zero next address
        send_tag(1'b1, 32'h0000_0000, {1'b0, ID_REFE}, 16'h0000, 32'hffff_ffff);
        send_tag(1'b1, 32'hffff_fff0, {1'b1, ID_CNT}, 16'hffff, 32'h0000_0000);
        send_tag(1'b0, 32'h0000_0100, {1'b0, ID_NEXT}, 16'h0001, 32'h0000_0000);
        send_tag(1'b0, 32'h0000_1000, {1'b0, ID_REF}, 16'h0001, 32'h1234_5678);
        send_tag(1'b0, 32'h0000_1010, {1'b1, ID_REFS}, 16'h8000, 32'hdead_bee0);
        // stack overflow, then pop back past empty
        send_tag(1'b0, 32'h0000_1100, {1'b0, ID_CALL}, 16'h0003, 32'h0000_2000);
        send_tag(1'b0, 32'h0000_2000, {1'b1, ID_CALL}, 16'h0000, 32'h0000_3000);
        send_tag(1'b0, 32'h0000_3000, {1'b0, ID_CALL}, 16'h0002, 32'h0000_4000);
        send_tag(1'b0, 32'h0000_3040, {1'b0, ID_RET}, 16'h0000, 32'h0000_0000);
        send_tag(1'b0, 32'h0000_2010, {1'b0, ID_RET}, 16'h0004, 32'hffff_ffff);
        send_tag(1'b0, 32'h0000_1140, {1'b1, ID_RET}, 16'h0000, 32'h0000_0000);
        // chain end with a non-empty stack
        send_tag(1'b1, 32'h0000_5000, {1'b0, ID_CALL}, 16'h0001, 32'h0000_6000);
        send_tag(1'b0, 32'h0000_6000, {1'b0, ID_END}, 16'h0002, 32'h0000_0000);
        // head tag empties the stack before a ret
        send_tag(1'b1, 32'h0000_7000, {1'b0, ID_RET}, 16'h0000, 32'h0000_0000);
        send_tag(1'b0, 32'h0000_7010, {1'b0, ID_CALL}, 16'h0000, 32'h0000_8000);
        send_tag(1'b0, 32'h0000_8000, {1'b1, ID_REFE}, 16'hffff, 32'h0000_9000);
        // unknown ids
        send_tag(1'b1, 32'h0000_a000, 8'h7f, 16'h0005, 32'h5555_5555);
        send_tag(1'b0, 32'h0000_a010, 8'hff, 16'hffff, 32'haaaa_aaaa);
        send_tag(1'b0, 32'hffff_ffff, 8'h01, 16'h0000, 32'hffff_ffff);
        send_tag(1'b1, 32'hffff_ffff, {1'b1, ID_END}, 16'hffff, 32'hffff_ffff);
        // return address wraps past the top of memory
        send_tag(1'b1, 32'hffff_fff0, {1'b0, ID_CALL}, 16'hffff, 32'h0000_0000);
        send_tag(1'b0, 32'h0000_0000, {1'b1, ID_RET}, 16'hffff, 32'h0000_0000);

        while (tags_sent < NUM_TAGS)
        begin
            random_chain();
        end
        tag_ch.valid <= 1'b0;

        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
        if (fails == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/dstw_pkg.sv
src/dstw_tag_if.sv
src/dstw_res_if.sv
src/dstw_front.sv
src/dstw_queue.sv
src/dstw_back.sv
src/dma_source_chain_tag_walker.sv
tb/tag_walk_checker.sv
tb/testbench.sv
